// ===== rtl/core/oai_pkg.sv =====
// Shared definitions for the ordered array block: field widths, command and
// status codes, and the command/status structs between controller and datapath.
// No dependencies.
package oai_pkg;

  localparam int CMD_W      = 3;
  localparam int POS_W      = 7;
  localparam int DATA_W     = 32;
  localparam int COUNT_W    = 7;
  localparam int STATUS_W   = 2;
  localparam int MAX_WORD_W = 64;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_WORD_WIDTH = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_READ   = 3'd4,
    CMD_WRITE  = 3'd5,
    CMD_SEARCH = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RA_CNT_M1,
    RA_POS,
    RA_CUR,
    RA_CUR_M1
  } rd_sel_t;

  typedef enum logic {
    WA_COUNT,
    WA_POS
  } wr_sel_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_POS_P1,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    MV_NONE,
    MV_UP,
    MV_DOWN
  } mv_op_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    mv_op_t  mv_op;
    logic    wr_word;
    wr_sel_t wr_sel;
    idx_op_t idx_op;
    cnt_op_t cnt_op;
    logic    hit_clr;
    logic    cmp;
    logic    take;
    logic    res_load;
    logic    res_use_data;
    status_t res_status;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic cur_gt_pos;
    logic cur_lt_cnt;
  } sts_t;

endpackage

// ===== rtl/core/oai_req_if.sv =====
// Command channel of the ordered array: valid/ready plus the command fields.
// Depends on oai_pkg.
interface oai_req_if;
  import oai_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, output cmd, output position, output data_in, input ready);
  modport sink   (input valid, input cmd, input position, input data_in, output ready);
endinterface

// ===== rtl/core/oai_rsp_if.sv =====
// Result channel of the ordered array: valid/ready plus the result fields.
// Depends on oai_pkg.
interface oai_rsp_if;
  import oai_pkg::*;

  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   data_out;
  logic                found;
  logic [COUNT_W-1:0]  count_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output data_out, output found, output count_out,
                  output status, input ready);
  modport sink   (input valid, input data_out, input found, input count_out,
                  input status, output ready);
endinterface

// ===== rtl/core/oai_dpath.sv =====
// Datapath of the ordered array: element memory, entry count, walk index,
// move pipeline, search compare and the result register.
// Depends on oai_pkg; driven by oai_ctrl through ctl_t, reports through sts_t.
module oai_dpath #(
  parameter int CAPACITY   = oai_pkg::DEF_CAPACITY,
  parameter int WORD_WIDTH = oai_pkg::DEF_WORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  oai_pkg::ctl_t                 ctl,
  output oai_pkg::sts_t                 sts,
  input  logic [oai_pkg::POS_W-1:0]     position,
  input  logic [oai_pkg::DATA_W-1:0]    data_in,
  output logic [oai_pkg::DATA_W-1:0]    data_out,
  output logic                          found,
  output logic [oai_pkg::COUNT_W-1:0]   count_out,
  output logic [oai_pkg::STATUS_W-1:0]  status
);
  import oai_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [WORD_WIDTH-1:0] mem [CAPACITY];

  logic [CW-1:0]         count;
  logic [CW-1:0]         cur;
  logic [CMPW-1:0]       pos_r;
  logic [WORD_WIDTH-1:0] word_r;
  logic [WORD_WIDTH-1:0] rdata;
  logic [WORD_WIDTH-1:0] hold;
  logic                  rd_valid;
  logic                  hit;
  logic                  mv_pend;
  logic [AW-1:0]         mv_addr;

  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic                  we;
  logic [WORD_WIDTH-1:0] wr_data;
  logic [CW-1:0]         cur_m1;
  logic [CW-1:0]         cnt_m1;
  logic [CMPW-1:0]       pos_p1;
  logic [CMPW-1:0]       cnt_c;
  logic [CMPW-1:0]       cur_c;
  logic [MAX_WORD_W-1:0] din_ext;
  logic [WORD_WIDTH+DATA_W-1:0] hold_ext;
  logic [CW+COUNT_W-1:0] cnt_ext;

  always_comb begin
    cur_m1   = cur - CW'(1);
    cnt_m1   = count - CW'(1);
    cnt_c    = CMPW'(count);
    cur_c    = CMPW'(cur);
    pos_p1   = pos_r + CMPW'(1);
    din_ext  = {{(MAX_WORD_W-DATA_W){1'b0}}, data_in};
    hold_ext = {{DATA_W{1'b0}}, hold};
    cnt_ext  = {{COUNT_W{1'b0}}, count};

    unique case (ctl.rd_sel)
      RA_CNT_M1: rd_addr = cnt_m1[AW-1:0];
      RA_POS:    rd_addr = pos_r[AW-1:0];
      RA_CUR:    rd_addr = cur[AW-1:0];
      RA_CUR_M1: rd_addr = cur_m1[AW-1:0];
    endcase

    // A pending move write always wins; the controller never schedules a
    // word write in the same cycle.
    we = mv_pend | ctl.wr_word;
    if (mv_pend) begin
      wr_addr = mv_addr;
      wr_data = rdata;
    end else begin
      wr_addr = (ctl.wr_sel == WA_COUNT) ? count[AW-1:0] : pos_r[AW-1:0];
      wr_data = word_r;
    end

    sts.full       = (count == CW'(CAPACITY));
    sts.empty      = (count == '0);
    sts.pos_gt_cnt = (pos_r > cnt_c);
    sts.pos_ge_cnt = (pos_r >= cnt_c);
    sts.cur_gt_pos = (cur_c > pos_r);
    sts.cur_lt_cnt = (cur < count);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      rd_valid <= 1'b0;
      mv_pend  <= 1'b0;
      hit      <= 1'b0;
    end else begin
      rd_valid <= ctl.rd_en;
      mv_pend  <= (ctl.mv_op != MV_NONE);
      case (ctl.cnt_op)
        CNT_INC: count <= count + CW'(1);
        CNT_DEC: count <= cnt_m1;
        default: count <= count;
      endcase
      if (ctl.hit_clr) begin
        hit <= 1'b0;
      end else if (ctl.cmp && rd_valid && (rdata == word_r)) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pos_r  <= CMPW'(position);
      word_r <= din_ext[WORD_WIDTH-1:0];
    end
    case (ctl.idx_op)
      IDX_ZERO:   cur <= '0;
      IDX_COUNT:  cur <= count;
      IDX_POS_P1: cur <= pos_p1[CW-1:0];
      IDX_INC:    cur <= cur + CW'(1);
      IDX_DEC:    cur <= cur_m1;
      default:    cur <= cur;
    endcase
    // Moving up writes to the slot above the one read, moving down below it.
    if (ctl.mv_op == MV_UP) begin
      mv_addr <= cur[AW-1:0];
    end else begin
      mv_addr <= cur_m1[AW-1:0];
    end
    if (ctl.take) begin
      hold <= rdata;
    end
    if (ctl.res_load) begin
      data_out  <= ctl.res_use_data ? hold_ext[DATA_W-1:0] : '0;
      found     <= hit;
      count_out <= cnt_ext[COUNT_W-1:0];
      status    <= ctl.res_status;
    end
  end

endmodule

// ===== rtl/core/oai_ctrl.sv =====
// Controller of the ordered array: decodes each command, sequences the
// memory walks of insert, remove and search, and runs the channel handshakes.
// Depends on oai_pkg; drives oai_dpath through ctl_t.
module oai_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [oai_pkg::CMD_W-1:0]  cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output oai_pkg::ctl_t              ctl,
  input  oai_pkg::sts_t              sts
);
  import oai_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TAKE,
    S_SEARCH,
    S_INS_SHIFT,
    S_INS_WORD,
    S_REM_TAKE,
    S_REM_SHIFT,
    S_RESULT
  } state_t;

  state_t           state;
  logic [CMD_W-1:0] cmd_r;
  status_t          status_r;
  logic             use_data_r;
  logic             slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    ctl              = '0;
    ctl.rd_sel       = RA_CUR;
    ctl.mv_op        = MV_NONE;
    ctl.wr_sel       = WA_POS;
    ctl.idx_op       = IDX_HOLD;
    ctl.cnt_op       = CNT_HOLD;
    ctl.res_use_data = use_data_r;
    ctl.res_status   = status_r;
    unique case (state)
      S_IDLE: begin
        ctl.load = in_valid;
      end
      S_DECODE: begin
        ctl.hit_clr = 1'b1;
        case (cmd_r)
          CMD_PUSH: begin
            if (!sts.full) begin
              ctl.wr_word = 1'b1;
              ctl.wr_sel  = WA_COUNT;
              ctl.cnt_op  = CNT_INC;
            end
          end
          CMD_POP: begin
            if (!sts.empty) begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RA_CNT_M1;
              ctl.cnt_op = CNT_DEC;
            end
          end
          CMD_INSERT: begin
            if (!sts.full && !sts.pos_gt_cnt) begin
              ctl.idx_op = IDX_COUNT;
            end
          end
          CMD_REMOVE: begin
            if (!sts.empty && !sts.pos_ge_cnt) begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RA_POS;
              ctl.idx_op = IDX_POS_P1;
            end
          end
          CMD_READ: begin
            if (!sts.pos_ge_cnt) begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RA_POS;
            end
          end
          CMD_WRITE: begin
            if (!sts.pos_ge_cnt) begin
              ctl.wr_word = 1'b1;
              ctl.wr_sel  = WA_POS;
            end
          end
          CMD_SEARCH: begin
            ctl.idx_op = IDX_ZERO;
          end
          default: begin
          end
        endcase
      end
      S_TAKE: begin
        ctl.take = 1'b1;
      end
      S_SEARCH: begin
        // Compares the word read in the previous cycle while reading the next.
        ctl.cmp = 1'b1;
        if (sts.cur_lt_cnt) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RA_CUR;
          ctl.idx_op = IDX_INC;
        end
      end
      S_INS_SHIFT: begin
        if (sts.cur_gt_pos) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RA_CUR_M1;
          ctl.mv_op  = MV_UP;
          ctl.idx_op = IDX_DEC;
        end
      end
      S_INS_WORD: begin
        ctl.wr_word = 1'b1;
        ctl.wr_sel  = WA_POS;
        ctl.cnt_op  = CNT_INC;
      end
      S_REM_TAKE, S_REM_SHIFT: begin
        ctl.take = (state == S_REM_TAKE);
        if (sts.cur_lt_cnt) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RA_CUR;
          ctl.mv_op  = MV_DOWN;
          ctl.idx_op = IDX_INC;
        end else begin
          ctl.cnt_op = CNT_DEC;
        end
      end
      S_RESULT: begin
        ctl.res_load = slot_free;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cmd_r      <= '0;
      status_r   <= ST_OK;
      use_data_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_RESULT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= cmd;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          status_r   <= ST_OK;
          use_data_r <= 1'b0;
          state      <= S_RESULT;
          case (cmd_r)
            CMD_PUSH: begin
              if (sts.full) begin
                status_r <= ST_FULL;
              end
            end
            CMD_POP: begin
              if (sts.empty) begin
                status_r <= ST_EMPTY;
              end else begin
                use_data_r <= 1'b1;
                state      <= S_TAKE;
              end
            end
            CMD_INSERT: begin
              if (sts.full) begin
                status_r <= ST_FULL;
              end else if (sts.pos_gt_cnt) begin
                status_r <= ST_RANGE;
              end else begin
                state <= S_INS_SHIFT;
              end
            end
            CMD_REMOVE: begin
              if (sts.empty) begin
                status_r <= ST_EMPTY;
              end else if (sts.pos_ge_cnt) begin
                status_r <= ST_RANGE;
              end else begin
                use_data_r <= 1'b1;
                state      <= S_REM_TAKE;
              end
            end
            CMD_READ: begin
              if (sts.pos_ge_cnt) begin
                status_r <= ST_RANGE;
              end else begin
                use_data_r <= 1'b1;
                state      <= S_TAKE;
              end
            end
            CMD_WRITE: begin
              if (sts.pos_ge_cnt) begin
                status_r <= ST_RANGE;
              end
            end
            CMD_SEARCH: begin
              state <= S_SEARCH;
            end
            default: begin
            end
          endcase
        end
        S_TAKE: begin
          state <= S_RESULT;
        end
        S_SEARCH: begin
          if (!sts.cur_lt_cnt) begin
            state <= S_RESULT;
          end
        end
        S_INS_SHIFT: begin
          if (!sts.cur_gt_pos) begin
            state <= S_INS_WORD;
          end
        end
        S_INS_WORD: begin
          state <= S_RESULT;
        end
        S_REM_TAKE, S_REM_SHIFT: begin
          if (sts.cur_lt_cnt) begin
            state <= S_REM_SHIFT;
          end else begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/ordered_array_insert_remove.sv =====
// Ordered array of up to CAPACITY words, one command per transfer on req and
// one result per command on rsp; every command goes through one memory with
// a write port and a registered read port. The next command is accepted only
// after the previous one has placed its result in the rsp register. The
// insert, remove and search walks move or compare one stored entry per cycle
// through that memory. A new command is accepted while the previous result
// still waits on rsp. After reset the array is empty and commands are
// accepted at once.
module ordered_array_insert_remove #(
  parameter int CAPACITY   = oai_pkg::DEF_CAPACITY,
  parameter int WORD_WIDTH = oai_pkg::DEF_WORD_WIDTH
) (
  input logic     clk,
  input logic     rst,
  oai_req_if.sink   req,
  oai_rsp_if.source rsp
);
  import oai_pkg::*;

  ctl_t ctl;
  sts_t sts;

  oai_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .cmd       (req.cmd),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  oai_dpath #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .position  (req.position),
    .data_in   (req.data_in),
    .data_out  (rsp.data_out),
    .found     (rsp.found),
    .count_out (rsp.count_out),
    .status    (rsp.status)
  );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for ordered_array_insert_remove: it drives commands on req and
// checks every result on rsp against a scoreboard that tracks the stored words and their count.
// Depends on oai_pkg, oai_req_if, oai_rsp_if and the block itself.
module testbench;
  import oai_pkg::*;

  localparam int RUN_CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES   = DEF_CAPACITY + 16;
  localparam int ITEMS_PER_PHASE = 433;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic               found;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } outcome_t;

  class array_scoreboard;
    logic [DATA_W-1:0] words [DEF_CAPACITY];
    int       fill = 0;
    outcome_t pending [$];
    int       errors = 0;
    int       checked = 0;
    int       status_seen [4] = '{0, 0, 0, 0};
    int       cmd_seen [8] = '{0, 0, 0, 0, 0, 0, 0, 0};

    function void place(int idx, logic [DATA_W-1:0] value);
      for (int k = fill; k > idx; k--) words[k] = words[k-1];
      words[idx] = value;
      fill++;
    endfunction

    function logic [DATA_W-1:0] extract(int idx);
      logic [DATA_W-1:0] value;
      value = words[idx];
      for (int k = idx; k + 1 < fill; k++) words[k] = words[k+1];
      fill--;
      return value;
    endfunction

    // Returns one of the stored words, so that a search can be aimed at a hit.
    function logic [DATA_W-1:0] any_stored();
      return words[$urandom_range(fill - 1)];
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] value);
      outcome_t r;
      int       at;
      at = int'(pos);
      r.data = '0;
      r.found = 1'b0;
      r.status = ST_OK;
      cmd_seen[cmd]++;
      case (cmd)
        CMD_PUSH: begin
          if (fill >= DEF_CAPACITY) r.status = ST_FULL;
          else place(fill, value);
        end
        CMD_POP: begin
          if (fill == 0) r.status = ST_EMPTY;
          else r.data = extract(fill - 1);
        end
        CMD_INSERT: begin
          // A full array is reported before a bad index.
          if (fill >= DEF_CAPACITY) r.status = ST_FULL;
          else if (at > fill) r.status = ST_RANGE;
          else place(at, value);
        end
        CMD_REMOVE: begin
          if (fill == 0) r.status = ST_EMPTY;
          else if (at >= fill) r.status = ST_RANGE;
          else r.data = extract(at);
        end
        CMD_READ: begin
          if (at >= fill) r.status = ST_RANGE;
          else r.data = words[at];
        end
        CMD_WRITE: begin
          if (at >= fill) r.status = ST_RANGE;
          else words[at] = value;
        end
        CMD_SEARCH: begin
          for (int k = 0; k < fill; k++) begin
            if (words[k] == value) r.found = 1'b1;
          end
        end
        default: ;
      endcase
      r.count = COUNT_W'(fill);
      pending.push_back(r);
    endfunction

    function void check_result(logic [DATA_W-1:0] data, logic found,
                               logic [COUNT_W-1:0] count, logic [STATUS_W-1:0] status);
      outcome_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing outstanding: data %h found %b count %0d status %0d",
                 $time, data, found, count, status);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      status_seen[status]++;
      if (data !== want.data) begin
        $display("%0t: data_out expected %h actual %h", $time, want.data, data);
        errors++;
      end
      if (found !== want.found) begin
        $display("%0t: found expected %b actual %b", $time, want.found, found);
        errors++;
      end
      if (count !== want.count) begin
        $display("%0t: count_out expected %0d actual %0d", $time, want.count, count);
        errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   cycles;

  array_scoreboard sb;

  oai_req_if req_ch ();
  oai_rsp_if rsp_ch ();

  ordered_array_insert_remove uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_result(rsp_ch.data_out, rsp_ch.found, rsp_ch.count_out, rsp_ch.status);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_command(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                              input logic [DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.cmd = c;
    req_ch.position = p;
    req_ch.data_in = d;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_command(c, p, d);
    @(negedge clk);
  endtask

  task automatic run_directed();
    send_command(CMD_POP, 7'd0, 32'h0);
    send_command(CMD_REMOVE, 7'd0, 32'h0);
    send_command(CMD_READ, 7'd0, 32'h0);
    send_command(CMD_WRITE, 7'd0, 32'hFFFF_FFFF);
    send_command(CMD_SEARCH, 7'd0, 32'h0);
    send_command(3'd7, 7'd127, 32'hFFFF_FFFF);
    send_command(CMD_INSERT, 7'd1, 32'h1111_1111);
    send_command(CMD_INSERT, 7'd0, 32'hFFFF_FFFF);
    send_command(CMD_PUSH, 7'd0, 32'h0);
    send_command(CMD_INSERT, 7'd2, 32'hA5A5_A5A5);
    send_command(CMD_INSERT, 7'd1, 32'h1234_5678);
    send_command(CMD_READ, 7'd0, 32'h0);
    send_command(CMD_READ, 7'd3, 32'h0);
    send_command(CMD_READ, 7'd4, 32'h0);
    send_command(CMD_SEARCH, 7'd0, 32'h1234_5678);
    send_command(CMD_SEARCH, 7'd0, 32'h8765_4321);
    send_command(CMD_WRITE, 7'd3, 32'h5A5A_5A5A);
    send_command(CMD_WRITE, 7'd127, 32'h0);
    send_command(CMD_REMOVE, 7'd127, 32'h0);
    send_command(CMD_REMOVE, 7'd1, 32'h0);
    send_command(CMD_REMOVE, 7'd0, 32'h0);
    send_command(CMD_POP, 7'd0, 32'h0);
    send_command(CMD_POP, 7'd0, 32'h0);
    send_command(CMD_POP, 7'd0, 32'h0);
    send_command(CMD_SEARCH, 7'd0, 32'hFFFF_FFFF);
  endtask

  // Bursts that mostly grow the array, mostly shrink it, or mix all codes, so the
  // full and empty corners are reached again and again.
  task automatic run_random(input int n);
    int                mode;
    int                burst_left;
    int                pick;
    logic [CMD_W-1:0]  c;
    logic [POS_W-1:0]  p;
    logic [DATA_W-1:0] d;
    mode = 0;
    burst_left = 140;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        mode = $urandom_range(2);
        burst_left = $urandom_range(120, 40);
      end
      burst_left--;
      pick = $urandom_range(99);
      if (mode == 0 && pick < 70) c = (pick < 35) ? CMD_PUSH : CMD_INSERT;
      else if (mode == 1 && pick < 70) c = (pick < 35) ? CMD_POP : CMD_REMOVE;
      else c = CMD_W'($urandom_range(7));
      if ($urandom_range(99) < 75) p = POS_W'($urandom_range(sb.fill));
      else p = POS_W'($urandom_range(127));
      pick = $urandom_range(99);
      if (pick < 60) d = $urandom;
      else if (pick < 75) d = 32'h0;
      else if (pick < 90) d = 32'hFFFF_FFFF;
      else d = 32'h1 << $urandom_range(31);
      if (c == CMD_SEARCH && sb.fill > 0 && $urandom_range(1) == 1) d = sb.any_stored();
      send_command(c, p, d);
    end
  endtask

  initial begin
    sb = new;
    rst = 1'b1;
    send_idle_pct = 17;
    recv_idle_pct = 48;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_PUSH;
    req_ch.position = '0;
    req_ch.data_in = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;
    run_directed();
    run_random(ITEMS_PER_PHASE);
    send_idle_pct = 48;
    recv_idle_pct = 17;
    run_random(ITEMS_PER_PHASE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(ITEMS_PER_PHASE);
    req_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d results: %0d push, %0d pop, %0d insert, %0d remove, %0d read,",
             sb.checked, sb.cmd_seen[CMD_PUSH], sb.cmd_seen[CMD_POP], sb.cmd_seen[CMD_INSERT],
             sb.cmd_seen[CMD_REMOVE], sb.cmd_seen[CMD_READ]);
    $display("%0d write, %0d search, %0d unused code; ok %0d, full %0d, empty %0d, range %0d.",
             sb.cmd_seen[CMD_WRITE], sb.cmd_seen[CMD_SEARCH], sb.cmd_seen[7],
             sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_RANGE]);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
